// ===== sv/cqbf_pkg.sv =====
// shared widths, function codes and control structs of the batch ring fifo
// no dependencies; imported by cqbf_ctrl, cqbf_dp and the top level
`default_nettype none

package cqbf_pkg;

  // fixed field widths
  localparam int FUNC_W   = 3;
  localparam int ELEM_W   = 32;
  localparam int CNT_W    = 7;
  localparam int OFF_W    = 8;
  localparam int IDX_W    = 8;
  localparam int LEN_W    = 9;

  // packed stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // parameter defaults
  localparam int DEF_DEPTH      = 256;
  localparam int DEF_ELEM_WIDTH = 32;
  localparam int DEF_MAX_BATCH  = 64;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_PUT    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DROP   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_STATUS = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic rd_issue;  // read next streamed element into the output stage
  } cqbf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_stream;  // current item is a get or peek that succeeds
    logic stream_last;   // one streamed element left
  } cqbf_sts_t;

endpackage

`default_nettype wire

// ===== sv/circular_queue_batch_fifo.sv =====
// latency: a put, drop, flush or status item gives its result in the cycle after acceptance
// throughput: such items are taken one per cycle while results are drained
// get/peek: after acceptance the elements are read, one per cycle while the output is free,
//   through the single-port slot memory; the next item is taken once the last read issues
// reset: async active low; pointers, counts and batch state clear, length goes to
//   min(DEPTH,256); slot memory is not cleared
`default_nettype none

module circular_queue_batch_fifo
  import cqbf_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
  parameter int MAX_BATCH  = DEF_MAX_BATCH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration: queue length register
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [LEN_W-1:0]       cfg_data_i,
  // input item stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // element[31:0], count[38:32], offset[46:39]
  input  wire logic [FUNC_W-1:0]      s_axis_tuser,  // func[2:0]
  // result item stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // element_out[31:0], used_count[39:32],
                                                     // free_count[47:40], is_full[48],
                                                     // is_empty[49]
  output logic                        m_axis_tuser,  // ok
  output logic                        m_axis_tlast
);

  cqbf_cmd_t         cmd;
  cqbf_sts_t         sts;
  logic              res_ok, res_last, res_full, res_empty;
  logic [ELEM_W-1:0] res_elem;
  logic [IDX_W-1:0]  res_used, res_free;

  // cfg_ready is tied high, so the user must write the length register only while idle
  assign cfg_ready_o = 1'b1;

  // handshake side: idle / stream sequencing and output valid
  cqbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  // pointers, batch tracking, slot memory and the registered result
  cqbf_dp #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH),
    .MAX_BATCH  (MAX_BATCH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (s_axis_tuser),
    .element_i     (s_axis_tdata[31:0]),
    .count_i       (s_axis_tdata[38:32]),
    .offset_i      (s_axis_tdata[46:39]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .ok_o          (res_ok),
    .element_out_o (res_elem),
    .last_o        (res_last),
    .used_o        (res_used),
    .free_o        (res_free),
    .full_o        (res_full),
    .empty_o       (res_empty)
  );

  // result packing, lowest field first, zero padded to whole bytes
  assign m_axis_tdata = {6'd0, res_empty, res_full, res_free, res_used, res_elem};
  assign m_axis_tuser = res_ok;
  assign m_axis_tlast = res_last;

endmodule

`default_nettype wire

// ===== sv/cqbf_ctrl.sv =====
// handshake controller of the batch ring fifo: idle / stream state machine
// depends on cqbf_pkg
`default_nettype none

module cqbf_ctrl
  import cqbf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      out_ready_i,
  input  wire cqbf_sts_t sts_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output cqbf_cmd_t      cmd_o
);

  typedef enum logic {ST_IDLE, ST_STREAM} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free    = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == ST_IDLE) && slot_free;
  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept   = in_valid_i && in_ready_o;
  assign cmd_o.rd_issue = (state_q == ST_STREAM) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept) begin
            if (sts_i.start_stream) begin
              state_q     <= ST_STREAM;
              out_valid_q <= 1'b0;
            end else begin
              out_valid_q <= 1'b1;
            end
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_STREAM: begin
          if (cmd_o.rd_issue) begin
            out_valid_q <= 1'b1;
            if (sts_i.stream_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/cqbf_dp.sv =====
// datapath of the batch ring fifo: pointers, batch tracking, slot memory, result stage
// depends on cqbf_pkg; driven by cqbf_ctrl
`default_nettype none

module cqbf_dp
  import cqbf_pkg::*;
#(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
  parameter int MAX_BATCH  = DEF_MAX_BATCH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [ELEM_W-1:0] element_i,
  input  wire logic [CNT_W-1:0]  count_i,
  input  wire logic [OFF_W-1:0]  offset_i,
  input  wire logic              cfg_we_i,
  input  wire logic [LEN_W-1:0]  cfg_data_i,
  input  wire cqbf_cmd_t         cmd_i,
  output cqbf_sts_t              sts_o,
  output logic                   ok_o,
  output logic [ELEM_W-1:0]      element_out_o,
  output logic                   last_o,
  output logic [IDX_W-1:0]       used_o,
  output logic [IDX_W-1:0]       free_o,
  output logic                   full_o,
  output logic                   empty_o
);

  localparam int LEN_MAX = (DEPTH < 256) ? DEPTH : 256;
  localparam int MEM_AW  = $clog2(LEN_MAX);

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                input logic [IDX_W-1:0] inc,
                                                input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] s;
    s = {1'b0, idx} + {1'b0, inc};
    return IDX_W'((s >= n) ? s - n : s);
  endfunction

  // control registers
  logic [LEN_W-1:0] len_q;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d, wpos_q, wpos_d, used_q, used_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             acc_q, acc_d;

  // payload registers
  logic [CNT_W-1:0]      total_q;
  logic [IDX_W-1:0]      rd_ptr_q;
  logic [CNT_W-1:0]      rd_left_q;
  logic [ELEM_WIDTH-1:0] rdata_q;
  logic                  out_ok_q, out_sel_q, out_last_q, out_full_q, out_empty_q;
  logic [IDX_W-1:0]      out_used_q, out_free_q;

  logic [ELEM_WIDTH-1:0] mem [LEN_MAX];

  // decode
  logic [LEN_W-1:0] nm1, free_now, peek_end;
  logic [LEN_W-1:0] len_clamp;
  logic             cnt_ok, is_open, new_acc, eff_acc, commit, mem_we;
  logic [CNT_W-1:0] eff_left, left_after, eff_total;
  logic [IDX_W-1:0] eff_wpos, wpos_inc, start_peek, head_after;
  logic             get_good, peek_good, drop_good;
  logic             res_ok;

  assign nm1       = len_q - LEN_W'(1);
  assign free_now  = nm1 - {1'b0, used_q};
  assign cnt_ok    = (count_i != '0) && (count_i <= CNT_W'(MAX_BATCH));
  assign is_open   = (left_q == '0);
  assign new_acc   = cnt_ok && ({2'b00, count_i} <= free_now);
  assign eff_acc   = is_open ? new_acc : acc_q;
  assign eff_left  = is_open ? ((count_i != '0) ? count_i : CNT_W'(1)) : left_q;
  assign eff_wpos  = is_open ? tail_q : wpos_q;
  assign eff_total = is_open ? count_i : total_q;
  assign left_after = eff_left - CNT_W'(1);
  assign wpos_inc  = wrap_add(eff_wpos, IDX_W'(1), len_q);
  assign commit    = (left_after == '0) && eff_acc;

  assign peek_end   = {1'b0, offset_i} + LEN_W'(count_i);
  assign get_good   = cnt_ok && ({1'b0, count_i} <= used_q);
  assign peek_good  = cnt_ok && (peek_end <= LEN_W'(used_q));
  assign drop_good  = (count_i != '0) && ({1'b0, count_i} <= used_q);
  assign start_peek = wrap_add(head_q, offset_i, len_q);
  assign head_after = wrap_add(head_q, IDX_W'(count_i), len_q);

  assign sts_o.start_stream = ((func_i == FUNC_GET) && get_good) ||
                              ((func_i == FUNC_PEEK) && peek_good);
  assign sts_o.stream_last  = (rd_left_q == CNT_W'(1));

  assign mem_we = cmd_i.accept && (func_i == FUNC_PUT) && eff_acc;

  always_comb begin
    if (cfg_data_i < LEN_W'(2)) begin
      len_clamp = LEN_W'(2);
    end else if (cfg_data_i > LEN_W'(LEN_MAX)) begin
      len_clamp = LEN_W'(LEN_MAX);
    end else begin
      len_clamp = cfg_data_i;
    end
  end

  // next pointer and batch state for an accepted item
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    wpos_d = wpos_q;
    used_d = used_q;
    left_d = '0;
    acc_d  = 1'b0;
    res_ok = 1'b0;
    unique case (func_i)
      FUNC_PUT: begin
        wpos_d = eff_acc ? wpos_inc : eff_wpos;
        left_d = left_after;
        acc_d  = (left_after == '0) ? 1'b0 : eff_acc;
        res_ok = eff_acc;
        if (commit) begin
          tail_d = wpos_inc;
          used_d = used_q + IDX_W'(eff_total);
        end
      end
      FUNC_GET: begin
        res_ok = get_good;
        if (get_good) begin
          head_d = head_after;
          used_d = used_q - IDX_W'(count_i);
        end
      end
      FUNC_PEEK: begin
        res_ok = peek_good;
      end
      FUNC_DROP: begin
        res_ok = drop_good;
        if (drop_good) begin
          head_d = head_after;
          used_d = used_q - IDX_W'(count_i);
        end
      end
      FUNC_FLUSH: begin
        head_d = tail_q;
        used_d = '0;
        res_ok = 1'b1;
      end
      FUNC_STATUS: begin
        res_ok = 1'b1;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_W'(LEN_MAX);
      head_q <= '0;
      tail_q <= '0;
      wpos_q <= '0;
      used_q <= '0;
      left_q <= '0;
      acc_q  <= 1'b0;
    end else if (cfg_we_i) begin
      len_q  <= len_clamp;
      head_q <= '0;
      tail_q <= '0;
      wpos_q <= '0;
      used_q <= '0;
      left_q <= '0;
      acc_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      head_q <= head_d;
      tail_q <= tail_d;
      wpos_q <= wpos_d;
      used_q <= used_d;
      left_q <= left_d;
      acc_q  <= acc_d;
    end
  end

  // stream pointer, batch length and result stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (func_i == FUNC_PUT) begin
        total_q <= eff_total;
      end
      rd_ptr_q    <= (func_i == FUNC_PEEK) ? start_peek : head_q;
      rd_left_q   <= count_i;
      out_ok_q    <= res_ok;
      out_sel_q   <= 1'b0;
      out_last_q  <= 1'b1;
      out_used_q  <= used_d;
      out_free_q  <= IDX_W'(nm1 - {1'b0, used_d});
      out_full_q  <= ({1'b0, used_d} == nm1);
      out_empty_q <= (used_d == '0);
    end else if (cmd_i.rd_issue) begin
      rd_ptr_q   <= wrap_add(rd_ptr_q, IDX_W'(1), len_q);
      rd_left_q  <= rd_left_q - CNT_W'(1);
      out_ok_q   <= 1'b1;
      out_sel_q  <= 1'b1;
      out_last_q <= (rd_left_q == CNT_W'(1));
    end
  end

  // slot memory, one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[eff_wpos[MEM_AW-1:0]] <= ELEM_WIDTH'(element_i);
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[rd_ptr_q[MEM_AW-1:0]];
    end
  end

  assign ok_o          = out_ok_q;
  assign element_out_o = out_sel_q ? ELEM_W'(rdata_q) : '0;
  assign last_o        = out_last_q;
  assign used_o        = out_used_q;
  assign free_o        = out_free_q;
  assign full_o        = out_full_q;
  assign empty_o       = out_empty_q;

endmodule

`default_nettype wire

// ===== tb/sv/circular_queue_batch_fifo_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the batch ring fifo: directed and random item streams,
// every result checked against a queue model kept inside the bench
// depends on cqbf_pkg and circular_queue_batch_fifo

module circular_queue_batch_fifo_tb;
  import cqbf_pkg::*;

  // func codes the block does not define, answered with a plain reject
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;

  localparam int RING_MAX    = (DEF_DEPTH < 256) ? DEF_DEPTH : 256;
  localparam int MAX_REPORTS = 10;

  // receiver behaviour: always ready, random short stalls, or long stalls
  typedef enum int {RX_STEADY, RX_CHOPPY, RX_BURSTY} rx_mode_e;

  typedef struct packed {
    logic              ok;
    logic [ELEM_W-1:0] data;
    logic              last;
    logic [7:0]        used_cnt;
    logic [7:0]        free_cnt;
    logic              full;
    logic              empty;
  } fifo_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [LEN_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // element[31:0], count[38:32], offset[46:39]
  logic [FUNC_W-1:0]      s_axis_tuser;   // func[2:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // element_out[31:0], used_count[39:32],
                                          // free_count[47:40], is_full[48], is_empty[49]
  logic                   m_axis_tuser;   // ok
  logic                   m_axis_tlast;

  // model of the ring: slot contents, pointers and the open put batch
  logic [ELEM_W-1:0] ring_mem [0:DEF_DEPTH-1];
  int                head_pos;
  int                tail_pos;
  int                batch_pos;
  int                batch_rem;
  bit                batch_ok;
  logic [LEN_W-1:0]  len_reg;

  // results still owed by the block, oldest first
  fifo_result_t fifo_results_due [$];

  int       error_count;
  int       items_sent;
  int       tx_burst;
  int       rx_hold;
  bit       tx_idle_on;
  rx_mode_e rx_mode;

  circular_queue_batch_fifo dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // queue model
  // ---------------------------------------------------------------------------

  function automatic int min_int(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // slots actually in use: the register is clamped to 2..256
  function automatic int ring_slots();
    int n;
    n = int'(len_reg);
    if (n < 2) n = 2;
    if (n > RING_MAX) n = RING_MAX;
    return n;
  endfunction

  function automatic int ring_used();
    int n;
    n = ring_slots();
    return ((tail_pos % n) + n - (head_pos % n)) % n;
  endfunction

  // every result carries the fill state after the step
  function automatic void queue_result(bit ok, logic [ELEM_W-1:0] data, bit last);
    fifo_result_t r;
    int n, used, freec;
    n = ring_slots();
    used = ring_used();
    freec = n - 1 - used;
    r.ok = ok;
    r.data = data;
    r.last = last;
    r.used_cnt = used[7:0];
    r.free_cnt = freec[7:0];
    r.full = (used == n - 1);
    r.empty = (used == 0);
    fifo_results_due.push_back(r);
  endfunction

  function automatic void ring_step(logic [FUNC_W-1:0] func, logic [ELEM_W-1:0] elem,
                                    logic [CNT_W-1:0] count, logic [OFF_W-1:0] offset);
    int n, used, c, off, start, i;
    bit good;
    n = ring_slots();
    used = ring_used();
    c = int'(count);
    off = int'(offset);
    if (func == FUNC_PUT) begin
      // the first item of a batch decides for the whole batch, later counts are ignored
      if (batch_rem == 0) begin
        batch_ok = (c >= 1) && (c <= DEF_MAX_BATCH) && (c <= n - 1 - used);
        batch_rem = (c > 0) ? c : 1;
        batch_pos = tail_pos % n;
      end
      if (batch_ok) begin
        ring_mem[batch_pos % n] = elem;
        batch_pos = (batch_pos + 1) % n;
      end
      batch_rem--;
      // tail only moves once the whole batch is in
      if (batch_rem == 0 && batch_ok) tail_pos = batch_pos;
      queue_result(batch_ok, '0, 1'b1);
      if (batch_rem == 0) batch_ok = 1'b0;
      return;
    end
    // anything else throws away an open batch
    batch_rem = 0;
    batch_ok = 1'b0;
    case (func)
      FUNC_GET, FUNC_PEEK: begin
        good = (c >= 1) && (c <= DEF_MAX_BATCH) &&
               ((func == FUNC_GET) ? (c <= used) : (off + c <= used));
        // peek position wraps round the ring
        start = (func == FUNC_GET) ? head_pos % n : ((head_pos % n) + off) % n;
        if (!good) begin
          queue_result(1'b0, '0, 1'b1);
        end else begin
          if (func == FUNC_GET) head_pos = (start + c) % n;
          for (i = 0; i < c; i++) queue_result(1'b1, ring_mem[(start + i) % n], i + 1 == c);
        end
      end
      FUNC_DROP: begin
        good = (c >= 1) && (c <= used);
        if (good) head_pos = ((head_pos % n) + c) % n;
        queue_result(good, '0, 1'b1);
      end
      FUNC_FLUSH: begin
        head_pos = tail_pos;
        queue_result(1'b1, '0, 1'b1);
      end
      default: begin
        queue_result(func == FUNC_STATUS, '0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void log_fault(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic string fmt_result(fifo_result_t r);
    return $sformatf("ok=%0b data=%h last=%0b used=%0d free=%0d full=%0b empty=%0b",
                     r.ok, r.data, r.last, r.used_cnt, r.free_cnt, r.full, r.empty);
  endfunction

  always @(posedge clk_i) begin : result_check
    fifo_result_t seen;
    fifo_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.ok       = m_axis_tuser;
      seen.data     = m_axis_tdata[ELEM_W-1:0];
      seen.last     = m_axis_tlast;
      seen.used_cnt = m_axis_tdata[ELEM_W+7:ELEM_W];
      seen.free_cnt = m_axis_tdata[ELEM_W+15:ELEM_W+8];
      seen.full     = m_axis_tdata[ELEM_W+16];
      seen.empty    = m_axis_tdata[ELEM_W+17];
      if (fifo_results_due.size() == 0) begin
        log_fault({"result with nothing outstanding: ", fmt_result(seen)});
      end else begin
        want = fifo_results_due.pop_front();
        if (seen !== want)
          log_fault({"result mismatch, expected ", fmt_result(want), " got ", fmt_result(seen)});
      end
    end
  end

  // receiver stall pattern, chosen per test
  always @(posedge clk_i) begin
    case (rx_mode)
      RX_STEADY: begin
        m_axis_tready <= 1'b1;
      end
      RX_CHOPPY: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (rx_hold > 0) begin
          rx_hold <= rx_hold - 1;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          rx_hold <= $urandom_range(1, 8);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one item on the input stream; the model is updated when the item is taken
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ELEM_W-1:0] elem,
                           input logic [CNT_W-1:0] count, input logic [OFF_W-1:0] offset);
    int gap;
    // bursts of random length with random gaps in between
    if (tx_idle_on && tx_burst == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      tx_burst = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, offset, count, elem};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ring_step(func, elem, count, offset);
    items_sent++;
    if (tx_burst > 0) tx_burst--;
  endtask

  // n_items put items; the first carries the batch length, the rest random counts
  task automatic put_run(input int n_items, input int c);
    int i;
    for (i = 0; i < n_items; i++)
      send_item(FUNC_PUT, $urandom, CNT_W'((i == 0) ? c : $urandom_range(0, 127)),
                OFF_W'($urandom_range(0, 255)));
  endtask

  // stop sending and wait until every owed result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (fifo_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // length register: only written with the block idle; empties the ring
  task automatic write_queue_len(input int v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[LEN_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    len_reg = v[LEN_W-1:0];
    head_pos = 0;
    tail_pos = 0;
    batch_pos = 0;
    batch_rem = 0;
    batch_ok = 1'b0;
  endtask

  // refusable count: 0, limit+1 (max 127) or above DEF_MAX_BATCH (not checked by drop)
  function automatic int bad_count(int limit);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return min_int(limit + 1, 127);
      default: return $urandom_range(DEF_MAX_BATCH + 1, 127);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every operation, field extremes and the reject paths at the reset length
  task automatic test_directed_ops();
    tx_idle_on = 1'b1;
    rx_mode = RX_CHOPPY;
    send_item(FUNC_STATUS, '0, '0, '0);              // empty after reset
    send_item(FUNC_GET, '1, 7'd1, '0);               // nothing to get
    send_item(FUNC_PEEK, '0, 7'd1, '0);
    send_item(FUNC_DROP, '0, 7'd1, '0);
    send_item(FUNC_PUT, '0, 7'd0, '0);               // zero-length batch refused
    send_item(FUNC_PUT, 32'h0000_0000, 7'd3, '0);
    send_item(FUNC_PUT, 32'hFFFF_FFFF, 7'd0, '1);    // count ignored inside a batch
    send_item(FUNC_PUT, 32'h5A5A_A5A5, 7'd127, '0);
    send_item(FUNC_PEEK, '0, 7'd2, 8'd1);
    send_item(FUNC_PEEK, '0, 7'd1, 8'd255);          // offset beyond the fill level
    send_item(FUNC_PEEK, '0, 7'd64, '0);             // more than held
    send_item(FUNC_GET, '0, 7'd127, '0);             // above the batch limit
    send_item(FUNC_GET, '0, 7'd0, '0);
    put_run(2, 4);                                   // batch of four, cut off below
    send_item(FUNC_STATUS, '1, '1, '1);
    send_item(FUNC_PUT, '1, 7'd100, '0);             // too long, refused
    send_item(FUNC_DROP, '0, 7'd127, '1);            // cuts the refused batch, too many
    send_item(FUNC_DROP, '0, 7'd1, '0);
    send_item(FUNC_GET, '0, 7'd2, '0);
    send_item(FUNC_RSVD_LO, '1, 7'd1, '0);
    send_item(FUNC_RSVD_HI, '0, 7'd1, '0);
    send_item(FUNC_PUT, 32'hDEAD_BEEF, 7'd1, '0);
    send_item(FUNC_FLUSH, '0, 7'd5, '0);
    send_item(FUNC_STATUS, '0, '0, '0);
  endtask

  // clamped and tiny lengths: fill, refuse when full, wrap the pointers
  task automatic test_length_extremes();
    int lens [7];
    int j, cap, k;
    lens = '{0, 1, 2, 3, 255, 257, 511};
    tx_idle_on = 1'b1;
    rx_mode = RX_BURSTY;
    for (j = 0; j < 7; j++) begin
      write_queue_len(lens[j]);
      cap = ring_slots() - 1;
      k = min_int(cap, 3);
      put_run(k, k);
      if (cap == k) send_item(FUNC_PUT, $urandom, 7'd1, '0);   // full
      send_item(FUNC_PEEK, $urandom, 7'd1, OFF_W'(k - 1));
      send_item(FUNC_GET, $urandom, 7'd1, '0);
      put_run(1, 1);                                          // tail wraps on small rings
      send_item(FUNC_GET, $urandom, CNT_W'(k), '0);
      send_item(FUNC_STATUS, $urandom, CNT_W'($urandom_range(0, 127)),
                OFF_W'($urandom_range(0, 255)));
    end
  endtask

  // a length write must discard a half-sent batch
  task automatic test_cut_batch_on_config();
    write_queue_len(RING_MAX);
    put_run(2, 5);
    write_queue_len(200);
    send_item(FUNC_STATUS, '0, '0, '0);
    put_run(2, 2);
    send_item(FUNC_GET, '0, 7'd2, '0);
  endtask

  // mostly well-formed batches and reads with random content, some broken ones
  task automatic random_op();
    int n, used, freec, sel, c, off, sent;
    n = ring_slots();
    used = ring_used();
    freec = n - 1 - used;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      if (freec > 0 && $urandom_range(0, 5) != 0) begin
        if (freec >= DEF_MAX_BATCH && $urandom_range(0, 15) == 0) c = DEF_MAX_BATCH;
        else c = $urandom_range(1, min_int(freec, 8));
        // now and then the batch is cut short by whatever follows
        sent = ($urandom_range(0, 9) == 0) ? $urandom_range(1, c) : c;
      end else begin
        c = bad_count(freec);
        sent = (c == 0) ? 1 : $urandom_range(1, min_int(c, 3));
      end
      put_run(sent, c);
    end else if (sel < 65) begin
      if (used > 0 && $urandom_range(0, 4) != 0)
        c = ($urandom_range(0, 7) == 0) ? min_int(used, DEF_MAX_BATCH)
                                        : $urandom_range(1, min_int(used, 12));
      else
        c = bad_count(used);
      send_item(FUNC_GET, $urandom, CNT_W'(c), OFF_W'($urandom_range(0, 255)));
    end else if (sel < 80) begin
      if (used > 0 && $urandom_range(0, 4) != 0) begin
        c = $urandom_range(1, min_int(used, 12));
        off = $urandom_range(0, used - c);
      end else begin
        c = $urandom_range(0, 127);
        off = $urandom_range(0, 255);
      end
      send_item(FUNC_PEEK, $urandom, CNT_W'(c), OFF_W'(off));
    end else if (sel < 90) begin
      if (used > 0 && $urandom_range(0, 3) != 0) c = $urandom_range(1, min_int(used, 127));
      else c = bad_count(used);
      send_item(FUNC_DROP, $urandom, CNT_W'(c), OFF_W'($urandom_range(0, 255)));
    end else if (sel < 95) begin
      send_item(FUNC_FLUSH, $urandom, CNT_W'($urandom_range(0, 127)),
                OFF_W'($urandom_range(0, 255)));
    end else if (sel < 98) begin
      send_item(FUNC_STATUS, $urandom, CNT_W'($urandom_range(0, 127)),
                OFF_W'($urandom_range(0, 255)));
    end else begin
      send_item(sel[0] ? FUNC_RSVD_HI : FUNC_RSVD_LO, $urandom,
                CNT_W'($urandom_range(0, 127)), OFF_W'($urandom_range(0, 255)));
    end
  endtask

  // four phases at different lengths and idling patterns
  task automatic test_random_traffic();
    int phase, len, first;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: len = RING_MAX;
        1: len = $urandom_range(2, 9);
        2: len = $urandom_range(10, 100);
        default: len = $urandom_range(0, 511);
      endcase
      write_queue_len(len);
      // first phase runs flat out on both sides
      tx_idle_on = (phase != 0);
      rx_mode = (phase == 0) ? RX_STEADY : ((phase == 2) ? RX_BURSTY : RX_CHOPPY);
      first = items_sent;
      while (items_sent - first < 16) random_op();
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    error_count = 0;
    items_sent = 0;
    tx_burst = 0;
    tx_idle_on = 1'b0;
    rx_mode = RX_STEADY;
    rx_hold = 0;
    len_reg = 9'd256;
    head_pos = 0;
    tail_pos = 0;
    batch_pos = 0;
    batch_rem = 0;
    batch_ok = 1'b0;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    m_axis_tready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_length_extremes();
    test_cut_batch_on_config();
    test_random_traffic();
    // allow for anything the block still emits
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
